/* hw/rtl/bcpd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpd_pkg
// Shared codes, limits and types of the blob-centring PD tracker.
// ----------------------------------------------------------------------------
package bcpd_pkg;

   localparam logic [1:0] CMD_BLOB    = 2'd0;
   localparam logic [1:0] CMD_END     = 2'd1;
   localparam logic [1:0] CMD_EMPTY   = 2'd2;
   localparam logic [1:0] CMD_RESTART = 2'd3;

   localparam logic [2:0] ST_IGNORED  = 3'd0;
   localparam logic [2:0] ST_LOST     = 3'd1;
   localparam logic [2:0] ST_CENTRED  = 3'd2;
   localparam logic [2:0] ST_RELEASE  = 3'd3;
   localparam logic [2:0] ST_TRACKING = 3'd4;
   localparam logic [2:0] ST_GO_DOWN  = 3'd5;

   localparam logic [2:0] REG_GAIN_P      = 3'd0;
   localparam logic [2:0] REG_GAIN_D      = 3'd1;
   localparam logic [2:0] REG_HOME_X      = 3'd2;
   localparam logic [2:0] REG_HOME_Y      = 3'd3;
   localparam logic [2:0] REG_HOLD_OFF    = 3'd4;
   localparam logic [2:0] REG_STABLE_HOLD = 3'd5;

   localparam logic [12:0] HOME_X_RESET      = 13'd3200;
   localparam logic [15:0] HOLD_OFF_RESET    = 16'd1000;
   localparam logic [15:0] STABLE_HOLD_RESET = 16'd3000;

   localparam int CENTRE_X     = 160;
   localparam int CENTRE_Y     = 120;
   localparam int MAX_BLOB_W   = 280;
   localparam int MAX_BLOB_H   = 200;
   localparam int ERR_SAT      = 1023;
   localparam int DEADBAND     = 15;
   localparam int RELEASE_BAND = 25;
   localparam int D_MAX        = 40;
   localparam int MOVE_GAP_MS  = 40;
   localparam int X_SPAN       = 1920;
   localparam int Y_LIMIT      = 4800;

   typedef struct packed {
      logic signed [10:0] err_x;
      logic signed [10:0] err_y;
      logic               in_deadband;
      logic               beyond_release;
      logic signed [14:0] pos_x;
      logic signed [13:0] pos_y;
   } pd_result_type;

   function automatic logic signed [10:0] sat_err(input logic signed [17:0] v);
      logic signed [10:0] r;
      if (v > 18'sd1023) begin
         r = 11'(ERR_SAT);
      end else if (v < -18'sd1023) begin
         r = -11'(ERR_SAT);
      end else begin
         r = v[10:0];
      end
      return r;
   endfunction

   function automatic logic signed [6:0] clamp_d(input logic signed [11:0] v);
      logic signed [6:0] r;
      if (v > 12'sd40) begin
         r = 7'(D_MAX);
      end else if (v < -12'sd40) begin
         r = -7'(D_MAX);
      end else begin
         r = v[6:0];
      end
      return r;
   endfunction

endpackage

/* hw/rtl/bcpd_pd_calc.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpd_pd_calc
// Centre error, band checks and one clamped PD step of the arm targets.
// ----------------------------------------------------------------------------
module bcpd_pd_calc (
   input  logic [15:0]               cand_x,
   input  logic [15:0]               cand_y,
   input  logic signed [10:0]        prev_err_x,
   input  logic signed [10:0]        prev_err_y,
   input  logic signed [14:0]        pos_x,
   input  logic signed [13:0]        pos_y,
   input  logic signed [15:0]        gain_p,
   input  logic signed [15:0]        gain_d,
   input  logic [12:0]               home_x,
   output bcpd_pkg::pd_result_type   result
);
   import bcpd_pkg::*;

   logic signed [17:0] diff_x, diff_y;
   logic signed [10:0] err_x, err_y;
   logic signed [11:0] dd_x, dd_y;
   logic signed [6:0]  d_x, d_y;
   logic signed [26:0] prod_px, prod_py;
   logic signed [22:0] prod_dx, prod_dy;
   logic signed [27:0] sum_x, sum_y;
   logic signed [27:0] rnd_x, rnd_y;
   logic signed [19:0] step_x, step_y;
   logic signed [20:0] new_x, new_y;
   logic signed [14:0] x_lo, x_hi;

   assign diff_x = 18'(CENTRE_X) - $signed({2'b00, cand_x});
   assign diff_y = 18'(CENTRE_Y) - $signed({2'b00, cand_y});
   assign err_x  = sat_err(diff_x);
   assign err_y  = sat_err(diff_y);

   assign dd_x = 12'(err_x) - 12'(prev_err_x);
   assign dd_y = 12'(err_y) - 12'(prev_err_y);
   assign d_x  = clamp_d(dd_x);
   assign d_y  = clamp_d(dd_y);

   // x moves on the vertical error, y on the horizontal one
   assign prod_px = 27'(err_y) * 27'(gain_p);
   assign prod_dx = 23'(d_y) * 23'(gain_d);
   assign prod_py = 27'(err_x) * 27'(gain_p);
   assign prod_dy = 23'(d_x) * 23'(gain_d);

   assign sum_x  = 28'(prod_px) + 28'(prod_dx);
   assign sum_y  = 28'(prod_py) + 28'(prod_dy);
   assign rnd_x  = sum_x + 28'sd128;
   assign rnd_y  = sum_y + 28'sd128;
   assign step_x = rnd_x[27:8];
   assign step_y = rnd_y[27:8];

   assign new_x = 21'(pos_x) + 21'(step_x);
   assign new_y = 21'(pos_y) + 21'(step_y);
   assign x_lo  = $signed({2'b00, home_x}) - 15'(X_SPAN);
   assign x_hi  = $signed({2'b00, home_x}) + 15'(X_SPAN);

   always_comb begin
      result.err_x = err_x;
      result.err_y = err_y;
      result.in_deadband = (err_x <= 11'(DEADBAND)) && (err_x >= -11'(DEADBAND)) &&
                           (err_y <= 11'(DEADBAND)) && (err_y >= -11'(DEADBAND));
      result.beyond_release = (err_x > 11'(RELEASE_BAND)) || (err_x < -11'(RELEASE_BAND)) ||
                              (err_y > 11'(RELEASE_BAND)) || (err_y < -11'(RELEASE_BAND));
      if (new_x < 21'(x_lo)) begin
         result.pos_x = x_lo;
      end else if (new_x > 21'(x_hi)) begin
         result.pos_x = x_hi;
      end else begin
         result.pos_x = new_x[14:0];
      end
      if (new_y < -21'(Y_LIMIT)) begin
         result.pos_y = -14'(Y_LIMIT);
      end else if (new_y > 21'(Y_LIMIT)) begin
         result.pos_y = 14'(Y_LIMIT);
      end else begin
         result.pos_y = new_y[13:0];
      end
   end

endmodule

/* hw/rtl/blob_centering_pd_tracker_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blob_centering_pd_tracker_unit
// Blob-centring PD tracker with deadband, release hysteresis and move limit.
// ----------------------------------------------------------------------------
// The unit takes one request per clock while the output is not stalled: a
// request is registered on acceptance in the input register, handled by one
// pass through the error, PD and clamp logic once the response register is
// free, and an end-of-report or empty-report request shows its response on
// rsp_ from the response register. Throughput is one request per cycle, set
// by the single compute stage between the input and response registers; the
// unit stalls only while a response waits on rsp_tready. Blob and restart
// requests give no response. Registers may be written only while idle.
// ----------------------------------------------------------------------------
module blob_centering_pd_tracker_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // name_match[0], blob_cx[16:1], blob_cy[32:17], blob_w[48:33],
   // blob_h[64:49], time_ms[96:65], zero[103:97]
   input  logic [103:0] req_tdata,
   // command[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // target_x[14:0], target_y[28:15], move_now[29], zero[31:30]
   output logic [31:0]  rsp_tdata,
   // status[2:0]
   output logic [2:0]   rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import bcpd_pkg::*;

   // configuration
   logic signed [15:0] gain_p_ff, gain_d_ff;
   logic [12:0]        home_x_ff;
   logic signed [13:0] home_y_ff;
   logic [15:0]        hold_off_ff, stable_hold_ff;
   logic               csr_write;

   // input register
   logic        s1_valid_ff;
   logic [1:0]  s1_cmd_ff;
   logic        s1_match_ff;
   logic [15:0] s1_cx_ff, s1_cy_ff, s1_w_ff, s1_h_ff;
   logic [31:0] s1_time_ff;

   // tracker state
   logic               tracking_ff, tracking_in;
   logic [31:0]        ignore_until_ff, ignore_until_in;
   logic               found_ff, found_in;
   logic [15:0]        cand_x_ff, cand_x_in, cand_y_ff, cand_y_in;
   logic signed [10:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic               locked_ff, locked_in;
   logic               stable_run_ff, stable_run_in;
   logic [31:0]        stable_start_ff, stable_start_in;
   logic signed [14:0] pos_x_ff, pos_x_in;
   logic signed [13:0] pos_y_ff, pos_y_in;
   logic [31:0]        move_stamp_ff, move_stamp_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_status_ff, rsp_status_in;
   logic signed [14:0] rsp_x_ff;
   logic signed [13:0] rsp_y_ff;
   logic               rsp_move_ff, rsp_move_in;

   logic          out_free, fire, emit;
   logic [31:0]   since_ignore, start_eff, since_stable, since_move;
   pd_result_type pd;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff      <= '0;
         gain_d_ff      <= '0;
         home_x_ff      <= HOME_X_RESET;
         home_y_ff      <= '0;
         hold_off_ff    <= HOLD_OFF_RESET;
         stable_hold_ff <= STABLE_HOLD_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[4:2])
            REG_GAIN_P:      gain_p_ff      <= csr_pwdata[15:0];
            REG_GAIN_D:      gain_d_ff      <= csr_pwdata[15:0];
            REG_HOME_X:      home_x_ff      <= csr_pwdata[12:0];
            REG_HOME_Y:      home_y_ff      <= csr_pwdata[13:0];
            REG_HOLD_OFF:    hold_off_ff    <= csr_pwdata[15:0];
            REG_STABLE_HOLD: stable_hold_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_GAIN_P:      csr_prdata = {16'd0, gain_p_ff};
         REG_GAIN_D:      csr_prdata = {16'd0, gain_d_ff};
         REG_HOME_X:      csr_prdata = {19'd0, home_x_ff};
         REG_HOME_Y:      csr_prdata = {18'd0, home_y_ff};
         REG_HOLD_OFF:    csr_prdata = {16'd0, hold_off_ff};
         REG_STABLE_HOLD: csr_prdata = {16'd0, stable_hold_ff};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_cmd_ff   <= req_tuser;
         s1_match_ff <= req_tdata[0];
         s1_cx_ff    <= req_tdata[16:1];
         s1_cy_ff    <= req_tdata[32:17];
         s1_w_ff     <= req_tdata[48:33];
         s1_h_ff     <= req_tdata[64:49];
         s1_time_ff  <= req_tdata[96:65];
      end
   end

   bcpd_pd_calc u_pd_calc (
      .cand_x     (cand_x_ff),
      .cand_y     (cand_y_ff),
      .prev_err_x (prev_x_ff),
      .prev_err_y (prev_y_ff),
      .pos_x      (pos_x_ff),
      .pos_y      (pos_y_ff),
      .gain_p     (gain_p_ff),
      .gain_d     (gain_d_ff),
      .home_x     (home_x_ff),
      .result     (pd)
   );

   assign since_ignore = s1_time_ff - ignore_until_ff;
   assign start_eff    = stable_run_ff ? stable_start_ff : s1_time_ff;
   assign since_stable = s1_time_ff - start_eff;
   assign since_move   = s1_time_ff - move_stamp_ff;

   always_comb begin
      tracking_in     = tracking_ff;
      ignore_until_in = ignore_until_ff;
      found_in        = found_ff;
      cand_x_in       = cand_x_ff;
      cand_y_in       = cand_y_ff;
      prev_x_in       = prev_x_ff;
      prev_y_in       = prev_y_ff;
      locked_in       = locked_ff;
      stable_run_in   = stable_run_ff;
      stable_start_in = stable_start_ff;
      pos_x_in        = pos_x_ff;
      pos_y_in        = pos_y_ff;
      move_stamp_in   = move_stamp_ff;
      emit            = 1'b0;
      rsp_status_in   = ST_IGNORED;
      rsp_move_in     = 1'b0;
      if (fire) begin
         unique case (s1_cmd_ff)
            CMD_BLOB: begin
               if (!found_ff && s1_match_ff && (s1_w_ff < 16'(MAX_BLOB_W)) &&
                   (s1_h_ff < 16'(MAX_BLOB_H))) begin
                  found_in  = 1'b1;
                  cand_x_in = s1_cx_ff;
                  cand_y_in = s1_cy_ff;
               end
            end
            CMD_RESTART: begin
               tracking_in     = 1'b1;
               found_in        = 1'b0;
               pos_x_in        = $signed({2'b00, home_x_ff});
               pos_y_in        = home_y_ff;
               prev_x_in       = '0;
               prev_y_in       = '0;
               locked_in       = 1'b0;
               stable_run_in   = 1'b0;
               ignore_until_in = s1_time_ff + {16'd0, hold_off_ff};
            end
            CMD_EMPTY: begin
               emit = 1'b1;
               if (tracking_ff) begin
                  prev_x_in     = '0;
                  prev_y_in     = '0;
                  stable_run_in = 1'b0;
                  rsp_status_in = ST_LOST;
               end
            end
            CMD_END: begin
               emit     = 1'b1;
               found_in = 1'b0;
               if (!tracking_ff || since_ignore[31]) begin
                  rsp_status_in = ST_IGNORED;
               end else if (!found_ff) begin
                  prev_x_in     = '0;
                  prev_y_in     = '0;
                  stable_run_in = 1'b0;
                  rsp_status_in = ST_LOST;
               end else if (pd.in_deadband) begin
                  locked_in       = 1'b1;
                  prev_x_in       = '0;
                  prev_y_in       = '0;
                  stable_start_in = start_eff;
                  if (since_stable >= {16'd0, stable_hold_ff}) begin
                     tracking_in   = 1'b0;
                     stable_run_in = 1'b0;
                     rsp_status_in = ST_GO_DOWN;
                  end else begin
                     stable_run_in = 1'b1;
                     rsp_status_in = ST_CENTRED;
                  end
               end else begin
                  stable_run_in = 1'b0;
                  if (locked_ff && !pd.beyond_release) begin
                     rsp_status_in = ST_RELEASE;
                  end else begin
                     locked_in     = 1'b0;
                     prev_x_in     = pd.err_x;
                     prev_y_in     = pd.err_y;
                     pos_x_in      = pd.pos_x;
                     pos_y_in      = pd.pos_y;
                     rsp_status_in = ST_TRACKING;
                     if (since_move >= 32'(MOVE_GAP_MS)) begin
                        move_stamp_in = s1_time_ff;
                        rsp_move_in   = 1'b1;
                     end
                  end
               end
            end
         endcase
      end
   end

   assign rsp_valid_in = out_free ? (fire && emit) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tracking_ff     <= 1'b0;
         ignore_until_ff <= '0;
         found_ff        <= 1'b0;
         cand_x_ff       <= '0;
         cand_y_ff       <= '0;
         prev_x_ff       <= '0;
         prev_y_ff       <= '0;
         locked_ff       <= 1'b0;
         stable_run_ff   <= 1'b0;
         stable_start_ff <= '0;
         pos_x_ff        <= $signed({2'b00, HOME_X_RESET});
         pos_y_ff        <= '0;
         move_stamp_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         tracking_ff     <= tracking_in;
         ignore_until_ff <= ignore_until_in;
         found_ff        <= found_in;
         cand_x_ff       <= cand_x_in;
         cand_y_ff       <= cand_y_in;
         prev_x_ff       <= prev_x_in;
         prev_y_ff       <= prev_y_in;
         locked_ff       <= locked_in;
         stable_run_ff   <= stable_run_in;
         stable_start_ff <= stable_start_in;
         pos_x_ff        <= pos_x_in;
         pos_y_ff        <= pos_y_in;
         move_stamp_ff   <= move_stamp_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && emit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_x_ff      <= pos_x_in;
         rsp_y_ff      <= pos_y_in;
         rsp_move_ff   <= rsp_move_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {2'b00, rsp_move_ff, rsp_y_ff, rsp_x_ff};

endmodule
